// ===== sv/tpsc_pkg.sv =====
`timescale 1ns / 1ps

package tpsc_pkg;

    // register map of the configuration port
    typedef enum logic [3:0] {
        CFG_HALF_PERIOD     = 4'd0,
        CFG_X_OFFSET        = 4'd1,
        CFG_Y_OFFSET        = 4'd2,
        CFG_PRESS_THRESHOLD = 4'd3,
        CFG_X_GAIN          = 4'd4,
        CFG_Y_GAIN          = 4'd5,
        CFG_X_SPAN          = 4'd6,
        CFG_Y_SPAN          = 4'd7
    } cfg_index_t;

    // converter commands
    localparam logic [7:0] CMD_X  = 8'hD0;
    localparam logic [7:0] CMD_Y  = 8'h90;
    localparam logic [7:0] CMD_Z1 = 8'hB0;

    // half phases of one conversion
    localparam logic [5:0] PHASE_CMD_FIRST  = 6'd1;
    localparam logic [5:0] PHASE_CMD_LAST   = 6'd16;
    localparam logic [5:0] PHASE_READ_FIRST = 6'd17;
    localparam logic [5:0] PHASE_READ_LAST  = 6'd48;
    localparam logic [5:0] PHASE_LAST       = 6'd49;

    // conversion order: x, x, x, y, y, y, z1
    localparam logic [2:0] CONV_FIRST_X  = 3'd0;
    localparam logic [2:0] CONV_LAST_X   = 3'd2;
    localparam logic [2:0] CONV_FIRST_Y  = 3'd3;
    localparam logic [2:0] CONV_SECOND_Y = 3'd4;
    localparam logic [2:0] CONV_LAST_Y   = 3'd5;
    localparam logic [2:0] CONV_LAST     = 3'd6;

    // register reset values
    localparam logic [15:0] RST_HALF_PERIOD     = 16'd64;
    localparam logic [11:0] RST_X_OFFSET        = 12'h050;
    localparam logic [11:0] RST_Y_OFFSET        = 12'h078;
    localparam logic [11:0] RST_PRESS_THRESHOLD = 12'd78;
    localparam logic [15:0] RST_X_GAIN          = 16'd16591;
    localparam logic [15:0] RST_Y_GAIN          = 16'd9947;
    localparam logic [11:0] RST_X_SPAN          = 12'd479;
    localparam logic [11:0] RST_Y_SPAN          = 12'd271;

endpackage

// ===== sv/touch_panel_scan_controller.sv =====
`timescale 1ns / 1ps

// Resistive touch panel scan controller with a bit-banged serial link.
// Input channel (s_valid/s_ready): one beat is one sequencer tick, carrying
// the sampled converter data bit s_miso and a scan request s_start_req,
// which is taken only on a tick that begins idle.
// Result channel (m_valid/m_ready): one beat per input beat, showing the
// serial pins, busy/done flags and the held touch result after that tick.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects one of the
// eight registers (half period, offsets, threshold, gains, spans); writes
// are always accepted and take effect on the next tick.
// A scan runs seven conversions of 50 half phases each; the coordinates are
// scaled in the tick that closes the last conversion.
// The result beat is registered from its input beat, and one beat is taken
// every cycle while the receiver does not stall: the state and the result
// register update together, with a single 12x16 multiply per axis in that path.
// When the receiver stalls, the result register holds and s_ready drops
// only while a result is waiting and m_ready is low.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears
// the held results and loads the register defaults.
module touch_panel_scan_controller #(
    parameter int ADC_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic        s_miso,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sclk,
    output logic        m_cs_n,
    output logic        m_mosi,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic        m_touched,
    output logic [11:0] m_x_pos,
    output logic [11:0] m_y_pos,
    output logic [11:0] m_pressure
);

    localparam int RAW_SHIFT = 16 - ADC_BITS;

    // configuration registers
    logic [15:0] half_period_reg;
    logic [11:0] x_offset_reg;
    logic [11:0] y_offset_reg;
    logic [11:0] press_threshold_reg;
    logic [15:0] x_gain_reg;
    logic [15:0] y_gain_reg;
    logic [11:0] x_span_reg;
    logic [11:0] y_span_reg;

    // sequencer state
    logic [15:0]         phase_timer_reg, phase_timer_next;
    logic [5:0]          phase_index_reg, phase_index_next;
    logic [2:0]          conv_index_reg, conv_index_next;
    logic [15:0]         shift_reg, shift_next;
    logic [ADC_BITS-1:0] first_x_raw_reg, first_x_raw_next;
    logic [ADC_BITS-1:0] second_y_raw_reg, second_y_raw_next;
    logic [11:0]         x_held_reg, x_held_next;
    logic [11:0]         y_held_reg, y_held_next;
    logic [11:0]         pressure_reg, pressure_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                touched_reg, touched_next;

    // result register
    logic        m_valid_reg;
    logic        sclk_reg, sclk_next;
    logic        cs_n_reg, cs_n_next;
    logic        mosi_reg, mosi_next;

    logic        in_beat;
    logic [15:0] hp;
    logic [16:0] timer_inc;
    logic        phase_end;
    logic [11:0] raw_now;
    logic [11:0] x_scaled;
    logic [11:0] y_scaled;
    logic [7:0]  cmd;
    logic [2:0]  cmd_bit;
    logic [5:0]  cmd_step;

    function automatic logic [11:0] scale_coord(
        input logic [11:0] raw,
        input logic [11:0] offset,
        input logic [15:0] gain,
        input logic [11:0] span
    );
        logic [11:0] diff;
        logic [27:0] prod;
        logic [11:0] s;
        diff = (raw < offset) ? 12'd0 : raw - offset;
        prod = {16'd0, diff} * {12'd0, gain};
        s    = prod[27:16];
        return (s > span) ? span : s;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_beat   = s_valid && s_ready;

    assign hp        = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign timer_inc = {1'b0, phase_timer_reg} + 17'd1;
    assign phase_end = timer_inc >= {1'b0, hp};
    assign raw_now   = 12'(shift_reg >> RAW_SHIFT);

    assign x_scaled = scale_coord(12'(first_x_raw_reg), x_offset_reg, x_gain_reg, x_span_reg);
    assign y_scaled = scale_coord(12'(second_y_raw_reg), y_offset_reg, y_gain_reg,
                                  y_span_reg);

    // next sequencer state for one tick
    always_comb begin
        phase_timer_next  = phase_timer_reg;
        phase_index_next  = phase_index_reg;
        conv_index_next   = conv_index_reg;
        shift_next        = shift_reg;
        first_x_raw_next  = first_x_raw_reg;
        second_y_raw_next = second_y_raw_reg;
        x_held_next       = x_held_reg;
        y_held_next       = y_held_reg;
        pressure_next     = pressure_reg;
        busy_next         = busy_reg;
        done_next         = done_reg;
        touched_next      = touched_reg;

        if (busy_reg) begin
            // miso is sampled on the last tick of each clock-high read phase
            if (phase_end && phase_index_reg[0] &&
                (phase_index_reg inside {[tpsc_pkg::PHASE_READ_FIRST:
                                          tpsc_pkg::PHASE_READ_LAST]})) begin
                shift_next = {shift_reg[14:0], s_miso};
            end
            if (phase_end) begin
                phase_timer_next = 16'd0;
                if (phase_index_reg != tpsc_pkg::PHASE_LAST) begin
                    phase_index_next = phase_index_reg + 6'd1;
                end else begin
                    phase_index_next = 6'd0;
                    shift_next       = 16'd0;
                    if (conv_index_reg == tpsc_pkg::CONV_FIRST_X) begin
                        first_x_raw_next = ADC_BITS'(shift_reg >> RAW_SHIFT);
                    end
                    if (conv_index_reg == tpsc_pkg::CONV_SECOND_Y) begin
                        second_y_raw_next = ADC_BITS'(shift_reg >> RAW_SHIFT);
                    end
                    if (conv_index_reg >= tpsc_pkg::CONV_LAST) begin
                        conv_index_next = 3'd0;
                        busy_next       = 1'b0;
                        done_next       = 1'b1;
                        if (raw_now > press_threshold_reg) begin
                            touched_next  = 1'b1;
                            pressure_next = raw_now;
                            x_held_next   = x_span_reg - x_scaled;
                            y_held_next   = y_scaled;
                        end else begin
                            touched_next  = 1'b0;
                            pressure_next = 12'd0;
                        end
                    end else begin
                        conv_index_next = conv_index_reg + 3'd1;
                    end
                end
            end else begin
                phase_timer_next = timer_inc[15:0];
            end
        end else begin
            done_next = 1'b0;
            if (s_start_req) begin
                busy_next        = 1'b1;
                phase_timer_next = 16'd0;
                phase_index_next = 6'd0;
                conv_index_next  = 3'd0;
                shift_next       = 16'd0;
            end
        end
    end

    // pin levels after the tick
    always_comb begin
        if (conv_index_next inside {[tpsc_pkg::CONV_FIRST_X:tpsc_pkg::CONV_LAST_X]}) begin
            cmd = tpsc_pkg::CMD_X;
        end else if (conv_index_next inside {[tpsc_pkg::CONV_FIRST_Y:
                                               tpsc_pkg::CONV_LAST_Y]}) begin
            cmd = tpsc_pkg::CMD_Y;
        end else begin
            cmd = tpsc_pkg::CMD_Z1;
        end
        cmd_step = phase_index_next - tpsc_pkg::PHASE_CMD_FIRST;
        cmd_bit  = 3'd7 - cmd_step[3:1];

        sclk_next = 1'b0;
        cs_n_next = 1'b1;
        mosi_next = 1'b0;
        if (busy_next) begin
            cs_n_next = (phase_index_next == tpsc_pkg::PHASE_LAST);
            if (phase_index_next inside {[tpsc_pkg::PHASE_CMD_FIRST:
                                          tpsc_pkg::PHASE_CMD_LAST]}) begin
                // mosi leads the rising edge by one half phase
                mosi_next = cmd[cmd_bit];
                sclk_next = !phase_index_next[0];
            end else if (phase_index_next inside {[tpsc_pkg::PHASE_READ_FIRST:
                                                   tpsc_pkg::PHASE_READ_LAST]}) begin
                sclk_next = phase_index_next[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg     <= tpsc_pkg::RST_HALF_PERIOD;
            x_offset_reg        <= tpsc_pkg::RST_X_OFFSET;
            y_offset_reg        <= tpsc_pkg::RST_Y_OFFSET;
            press_threshold_reg <= tpsc_pkg::RST_PRESS_THRESHOLD;
            x_gain_reg          <= tpsc_pkg::RST_X_GAIN;
            y_gain_reg          <= tpsc_pkg::RST_Y_GAIN;
            x_span_reg          <= tpsc_pkg::RST_X_SPAN;
            y_span_reg          <= tpsc_pkg::RST_Y_SPAN;
        end else if (cfg_valid) begin
            case (cfg_index)
                tpsc_pkg::CFG_HALF_PERIOD:     half_period_reg     <= cfg_data;
                tpsc_pkg::CFG_X_OFFSET:        x_offset_reg        <= cfg_data[11:0];
                tpsc_pkg::CFG_Y_OFFSET:        y_offset_reg        <= cfg_data[11:0];
                tpsc_pkg::CFG_PRESS_THRESHOLD: press_threshold_reg <= cfg_data[11:0];
                tpsc_pkg::CFG_X_GAIN:          x_gain_reg          <= cfg_data;
                tpsc_pkg::CFG_Y_GAIN:          y_gain_reg          <= cfg_data;
                tpsc_pkg::CFG_X_SPAN:          x_span_reg          <= cfg_data[11:0];
                tpsc_pkg::CFG_Y_SPAN:          y_span_reg          <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_timer_reg  <= 16'd0;
            phase_index_reg  <= 6'd0;
            conv_index_reg   <= 3'd0;
            shift_reg        <= 16'd0;
            first_x_raw_reg  <= '0;
            second_y_raw_reg <= '0;
            x_held_reg       <= 12'd0;
            y_held_reg       <= 12'd0;
            pressure_reg     <= 12'd0;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            touched_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (in_beat) begin
                phase_timer_reg  <= phase_timer_next;
                phase_index_reg  <= phase_index_next;
                conv_index_reg   <= conv_index_next;
                shift_reg        <= shift_next;
                first_x_raw_reg  <= first_x_raw_next;
                second_y_raw_reg <= second_y_raw_next;
                x_held_reg       <= x_held_next;
                y_held_reg       <= y_held_next;
                pressure_reg     <= pressure_next;
                busy_reg         <= busy_next;
                done_reg         <= done_next;
                touched_reg      <= touched_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // pin levels ride with the result beat
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            sclk_reg <= sclk_next;
            cs_n_reg <= cs_n_next;
            mosi_reg <= mosi_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sclk     = sclk_reg;
    assign m_cs_n     = cs_n_reg;
    assign m_mosi     = mosi_reg;
    assign m_busy_res = busy_reg;
    assign m_done_res = done_reg;
    assign m_touched  = touched_reg;
    assign m_x_pos    = x_held_reg;
    assign m_y_pos    = y_held_reg;
    assign m_pressure = pressure_reg;

endmodule

// ===== tb/touch_panel_scan_controller_tb.sv =====
`timescale 1ns / 1ps

module touch_panel_scan_controller_tb;

    localparam int ADC_BITS    = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic        sclk;
        logic        cs_n;
        logic        mosi;
        logic        busy_res;
        logic        done_res;
        logic        touched;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [11:0] pressure;
    } pin_frame_t;

    typedef enum {MISO_RANDOM, MISO_ZERO, MISO_ONE, MISO_SPARSE} miso_mode_t;

    class touch_scan_board;
        logic [15:0] half_period;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic [11:0] press_threshold;
        logic [15:0] x_gain;
        logic [15:0] y_gain;
        logic [11:0] x_span;
        logic [11:0] y_span;

        logic [15:0] phase_timer;
        logic [5:0]  phase_index;
        logic [2:0]  conv_index;
        logic [15:0] shift_bits;
        logic [11:0] first_x_raw;
        logic [11:0] second_y_raw;
        logic [11:0] x_held;
        logic [11:0] y_held;
        logic [11:0] pressure_held;
        logic        busy;
        logic        done;
        logic        touched;

        pin_frame_t  frames_due[$];
        int          mismatches;

        function new();
            half_period     = tpsc_pkg::RST_HALF_PERIOD;
            x_offset        = tpsc_pkg::RST_X_OFFSET;
            y_offset        = tpsc_pkg::RST_Y_OFFSET;
            press_threshold = tpsc_pkg::RST_PRESS_THRESHOLD;
            x_gain          = tpsc_pkg::RST_X_GAIN;
            y_gain          = tpsc_pkg::RST_Y_GAIN;
            x_span          = tpsc_pkg::RST_X_SPAN;
            y_span          = tpsc_pkg::RST_Y_SPAN;
            phase_timer     = '0;
            phase_index     = '0;
            conv_index      = '0;
            shift_bits      = '0;
            first_x_raw     = '0;
            second_y_raw    = '0;
            x_held          = '0;
            y_held          = '0;
            pressure_held   = '0;
            busy            = 1'b0;
            done            = 1'b0;
            touched         = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_reg(tpsc_pkg::cfg_index_t idx, logic [15:0] data);
            case (idx)
                tpsc_pkg::CFG_HALF_PERIOD:     half_period     = data;
                tpsc_pkg::CFG_X_OFFSET:        x_offset        = data[11:0];
                tpsc_pkg::CFG_Y_OFFSET:        y_offset        = data[11:0];
                tpsc_pkg::CFG_PRESS_THRESHOLD: press_threshold = data[11:0];
                tpsc_pkg::CFG_X_GAIN:          x_gain          = data;
                tpsc_pkg::CFG_Y_GAIN:          y_gain          = data;
                tpsc_pkg::CFG_X_SPAN:          x_span          = data[11:0];
                tpsc_pkg::CFG_Y_SPAN:          y_span          = data[11:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] conv_raw();
            return 12'(shift_bits >> (16 - ADC_BITS));
        endfunction

        function logic [11:0] scaled(logic [11:0] raw, logic [11:0] offset,
                                     logic [15:0] gain, logic [11:0] span);
            logic [11:0] clamped;
            logic [27:0] product;
            logic [11:0] coord;
            clamped = (raw < offset) ? offset : raw;
            product = {16'd0, clamped - offset} * {12'd0, gain};
            coord   = product[27:16];
            return (coord > span) ? span : coord;
        endfunction

        function void close_phase();
            logic [11:0] z1;
            if (phase_index < tpsc_pkg::PHASE_LAST) begin
                phase_index++;
                return;
            end
            phase_index = '0;
            if (conv_index == tpsc_pkg::CONV_FIRST_X) first_x_raw = conv_raw();
            if (conv_index == tpsc_pkg::CONV_SECOND_Y) second_y_raw = conv_raw();
            if (conv_index >= tpsc_pkg::CONV_LAST) begin
                z1         = conv_raw();
                conv_index = '0;
                busy       = 1'b0;
                done       = 1'b1;
                touched    = 1'b0;
                if (z1 > press_threshold) begin
                    touched       = 1'b1;
                    pressure_held = z1;
                    x_held = x_span - scaled(first_x_raw, x_offset, x_gain, x_span);
                    y_held = scaled(second_y_raw, y_offset, y_gain, y_span);
                end else begin
                    pressure_held = '0;
                end
            end else begin
                conv_index++;
            end
            shift_bits = '0;
        endfunction

        function void note_tick(logic start, logic miso);
            logic [16:0] period;
            logic [7:0]  cmd;
            int          bit_pos;
            pin_frame_t  f;
            // a zero half period behaves as one tick
            period = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
            if (busy) begin
                if ({1'b0, phase_timer} + 17'd1 >= period) begin
                    if (phase_index >= tpsc_pkg::PHASE_READ_FIRST &&
                        phase_index <= tpsc_pkg::PHASE_READ_LAST && phase_index[0])
                        shift_bits = {shift_bits[14:0], miso};
                    phase_timer = '0;
                    close_phase();
                end else begin
                    phase_timer++;
                end
            end else begin
                done = 1'b0;
                if (start) begin
                    busy        = 1'b1;
                    phase_timer = '0;
                    phase_index = '0;
                    conv_index  = '0;
                    shift_bits  = '0;
                end
            end

            f.sclk = 1'b0;
            f.cs_n = 1'b1;
            f.mosi = 1'b0;
            if (busy) begin
                f.cs_n = (phase_index == tpsc_pkg::PHASE_LAST);
                cmd = (conv_index <= tpsc_pkg::CONV_LAST_X) ? tpsc_pkg::CMD_X :
                      (conv_index <= tpsc_pkg::CONV_LAST_Y) ? tpsc_pkg::CMD_Y :
                      tpsc_pkg::CMD_Z1;
                if (phase_index >= tpsc_pkg::PHASE_CMD_FIRST &&
                    phase_index <= tpsc_pkg::PHASE_CMD_LAST) begin
                    bit_pos = 7 - ((int'(phase_index) - 1) >> 1);
                    f.mosi  = cmd[bit_pos];
                    f.sclk  = ~phase_index[0];
                end else if (phase_index >= tpsc_pkg::PHASE_READ_FIRST &&
                             phase_index <= tpsc_pkg::PHASE_READ_LAST) begin
                    f.sclk = phase_index[0];
                end
            end
            f.busy_res = busy;
            f.done_res = done;
            f.touched  = touched;
            f.x_pos    = x_held;
            f.y_pos    = y_held;
            f.pressure = pressure_held;
            frames_due.push_back(f);
        endfunction

        function void compare(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(pin_frame_t got);
            pin_frame_t want;
            if (frames_due.size() == 0) begin
                $error("result beat with no tick pending");
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            compare("sclk", 12'(want.sclk), 12'(got.sclk));
            compare("cs_n", 12'(want.cs_n), 12'(got.cs_n));
            compare("mosi", 12'(want.mosi), 12'(got.mosi));
            compare("busy_res", 12'(want.busy_res), 12'(got.busy_res));
            compare("done_res", 12'(want.done_res), 12'(got.done_res));
            compare("touched", 12'(want.touched), 12'(got.touched));
            compare("x_pos", want.x_pos, got.x_pos);
            compare("y_pos", want.y_pos, got.y_pos);
            compare("pressure", want.pressure, got.pressure);
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index   = tpsc_pkg::CFG_HALF_PERIOD;
    logic [15:0] cfg_data    = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_start_req = 1'b0;
    logic        s_miso      = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_sclk;
    logic        m_cs_n;
    logic        m_mosi;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_touched;
    logic [11:0] m_x_pos;
    logic [11:0] m_y_pos;
    logic [11:0] m_pressure;

    touch_scan_board scan_board;
    pin_frame_t      seen_frame;
    miso_mode_t      miso_mode   = MISO_RANDOM;
    logic            calm        = 1'b0;
    logic            hold_req    = 1'b0;
    bit              hold_taken  = 1'b0;
    int              hold_left   = 0;
    int              cycle_count = 0;

    touch_panel_scan_controller #(
        .ADC_BITS(ADC_BITS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_start_req(s_start_req),
        .s_miso     (s_miso),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sclk     (m_sclk),
        .m_cs_n     (m_cs_n),
        .m_mosi     (m_mosi),
        .m_busy_res (m_busy_res),
        .m_done_res (m_done_res),
        .m_touched  (m_touched),
        .m_x_pos    (m_x_pos),
        .m_y_pos    (m_y_pos),
        .m_pressure (m_pressure)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_frame = '{sclk: m_sclk, cs_n: m_cs_n, mosi: m_mosi,
                           busy_res: m_busy_res, done_res: m_done_res,
                           touched: m_touched, x_pos: m_x_pos, y_pos: m_y_pos,
                           pressure: m_pressure};
            scan_board.check_result(seen_frame);
        end
    end

    function automatic logic next_miso();
        case (miso_mode)
            MISO_ZERO:   return 1'b0;
            MISO_ONE:    return 1'b1;
            MISO_SPARSE: return ($urandom_range(0, 7) == 0);
            default:     return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick(logic start, logic miso);
        if (!calm && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= start;
        s_miso      <= miso;
        do @(posedge aclk); while (!s_ready);
        scan_board.note_tick(start, miso);
    endtask

    task automatic write_cfg(tpsc_pkg::cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        scan_board.write_reg(idx, data);
    endtask

    task automatic apply_setting(logic [15:0] period, logic [11:0] xo, logic [11:0] yo,
                                 logic [11:0] thr, logic [15:0] xg, logic [15:0] yg,
                                 logic [11:0] xs, logic [11:0] ys);
        write_cfg(tpsc_pkg::CFG_HALF_PERIOD, period);
        write_cfg(tpsc_pkg::CFG_X_OFFSET, {4'd0, xo});
        write_cfg(tpsc_pkg::CFG_Y_OFFSET, {4'd0, yo});
        write_cfg(tpsc_pkg::CFG_PRESS_THRESHOLD, {4'd0, thr});
        write_cfg(tpsc_pkg::CFG_X_GAIN, xg);
        write_cfg(tpsc_pkg::CFG_Y_GAIN, yg);
        write_cfg(tpsc_pkg::CFG_X_SPAN, {4'd0, xs});
        write_cfg(tpsc_pkg::CFG_Y_SPAN, {4'd0, ys});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (scan_board.frames_due.size() != 0);
    endtask

    // run the scan out to idle, then let every result beat arrive
    task automatic settle();
        while (scan_board.busy) send_tick(1'($urandom_range(0, 1)), next_miso());
        wait_drained();
    endtask

    task automatic run_random(int count);
        logic start;
        for (int i = 0; i < count; i++) begin
            start = ($urandom_range(0, 3) == 0);
            if (start && !scan_board.busy) miso_mode = miso_mode_t'($urandom_range(0, 3));
            send_tick(start, next_miso());
        end
    endtask

    initial begin
        scan_board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle pins at reset settings
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        wait_drained();
        write_cfg(tpsc_pkg::CFG_HALF_PERIOD, 16'd1);
        cfg_valid <= 1'b0;
        @(posedge aclk);

        // full-scale scan, with start toggled while busy
        miso_mode = MISO_ONE;
        send_tick(1'b1, 1'b1);
        for (int i = 0; i < 12; i++) send_tick(1'(i % 2), 1'b1);
        settle();
        // no pressure: coordinates stay, pressure reads zero
        miso_mode = MISO_ZERO;
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        settle();

        apply_setting(16'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        run_random(100);
        wait_drained();
        run_random(100);
        settle();

        apply_setting(16'd2, 12'hFFF, 12'hFFF, 12'd0, 16'd0, 16'd0, 12'd0, 12'd0);
        calm <= 1'b1;
        run_random(200);
        calm <= 1'b0;
        run_random(50);
        settle();

        apply_setting(16'd1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      12'hFFF, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        run_random(50);
        hold_req <= 1'b1;
        run_random(150);
        settle();

        apply_setting(16'd1, 12'($urandom_range(0, 600)), 12'($urandom_range(0, 600)),
                      12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
        run_random(150);
        settle();

        apply_setting(16'd1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
        run_random(150);
        settle();

        // longest half period: the timer runs, the scan never leaves phase 0
        apply_setting(16'hFFFF, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
        run_random(100);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (scan_board.mismatches == 0 && scan_board.frames_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
